FILE: hdl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Types, constants and the control store of the ChaCha20 byte cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned UpcW     = 4;
  localparam int unsigned RndW     = 4;
  localparam logic [RndW-1:0] LastDoubleRound = RndW'(9);

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_PART0  = 3'd0,
    CFG_KEY_PART1  = 3'd1,
    CFG_KEY_PART2  = 3'd2,
    CFG_KEY_PART3  = 3'd3,
    CFG_NONCE_LOW  = 3'd4,
    CFG_NONCE_HIGH = 3'd5,
    CFG_START_BLK  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT16 = 2'd0,
    ROT12 = 2'd1,
    ROT8  = 2'd2,
    ROT7  = 2'd3
  } rot_t;

  typedef struct packed {
    logic            load;
    logic            qr;
    logic            cd;
    rot_t            rot;
    logic            diag;
    logic            loop;
    logic            fin;
    logic [UpcW-1:0] jmp;
  } ucw_t;

  localparam logic [UpcW-1:0] UpcLoad = UpcW'(0);
  localparam logic [UpcW-1:0] UpcBody = UpcW'(1);

  function automatic ucw_t ucode(input logic [UpcW-1:0] step);
    ucw_t w;
    w = '{load: 1'b0, qr: 1'b0, cd: 1'b0, rot: ROT16, diag: 1'b0,
          loop: 1'b0, fin: 1'b0, jmp: UpcLoad};
    unique case (step)
      4'd0: w.load = 1'b1;
      4'd1: begin w.qr = 1'b1; w.cd = 1'b0; w.rot = ROT16; end
      4'd2: begin w.qr = 1'b1; w.cd = 1'b1; w.rot = ROT12; end
      4'd3: begin w.qr = 1'b1; w.cd = 1'b0; w.rot = ROT8;  end
      4'd4: begin w.qr = 1'b1; w.cd = 1'b1; w.rot = ROT7;  end
      4'd5: begin w.qr = 1'b1; w.cd = 1'b0; w.rot = ROT16; w.diag = 1'b1; end
      4'd6: begin w.qr = 1'b1; w.cd = 1'b1; w.rot = ROT12; w.diag = 1'b1; end
      4'd7: begin w.qr = 1'b1; w.cd = 1'b0; w.rot = ROT8;  w.diag = 1'b1; end
      4'd8: begin
        w.qr = 1'b1; w.cd = 1'b1; w.rot = ROT7; w.diag = 1'b1;
        w.loop = 1'b1; w.jmp = UpcBody;
      end
      4'd9: w.fin = 1'b1;
      default: w.fin = 1'b1;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rotl_sel(input logic [31:0] v, input rot_t r);
    logic [31:0] y;
    unique case (r)
      ROT16: y = {v[15:0], v[31:16]};
      ROT12: y = {v[19:0], v[31:20]};
      ROT8:  y = {v[23:0], v[31:24]};
      ROT7:  y = {v[24:0], v[31:25]};
      default: y = v;
    endcase
    return y;
  endfunction

endpackage

FILE: hdl/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 byte cipher: XOR of each request byte with the keystream, with
// blocks built on demand by a microcoded four-lane quarter-round datapath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in_     | input     | in_valid / in_ready  | in_data  (in_byte, is_last)
//   out_    | output    | out_valid / out_ready| out_data (out_byte, out_last)
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// A byte within a block is taken whenever the output register is free. The
// first byte of a message and the first byte after each 64-byte boundary
// wait for the block build: the start, one load step, 80 single-add steps
// (10 double rounds of 8 steps on four lanes) and one feed-forward step.
// Reset is synchronous; a stalled output register holds the result and
// takes the next request once out_ready frees it.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  cc20_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output cc20_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [cc20_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [cc20_pkg::CfgDataW-1:0]        cfg_wdata
);
  import cc20_pkg::*;

  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_lo_r;
  logic [31:0] nonce_hi_r, start_blk_r;

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] ks_r [16];
  logic [31:0] init [16];

  logic            busy_r;
  logic [UpcW-1:0] upc_r;
  logic [RndW-1:0] rnd_r;
  logic            in_msg_r;
  logic [5:0]      pos_r;
  logic            fresh_r;
  logic [31:0]     blk_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  ucw_t        ucw;
  logic        need_blk;
  logic        start;
  logic        in_fire;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  assign ucw      = ucode(upc_r);
  assign need_blk = !in_msg_r || ((pos_r == 6'd0) && !fresh_r);
  assign in_ready = !busy_r && !need_blk && (!out_valid_r || out_ready);
  assign start    = !busy_r && in_valid && need_blk;
  assign in_fire  = in_valid && in_ready;
  assign ks_word  = ks_r[pos_r[5:2]];
  assign ks_byte  = ks_word[{pos_r[1:0], 3'b000} +: 8];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    init[0]  = Sigma0;            init[1]  = Sigma1;
    init[2]  = Sigma2;            init[3]  = Sigma3;
    init[4]  = key0_r[31:0];      init[5]  = key0_r[63:32];
    init[6]  = key1_r[31:0];      init[7]  = key1_r[63:32];
    init[8]  = key2_r[31:0];      init[9]  = key2_r[63:32];
    init[10] = key3_r[31:0];      init[11] = key3_r[63:32];
    init[12] = blk_r;
    init[13] = nonce_lo_r[31:0];  init[14] = nonce_lo_r[63:32];
    init[15] = nonce_hi_r;
  end

  always_comb begin
    logic [31:0] sa, sb, sc, sd, na, nb, nc, nd;
    sa = '0;
    sb = '0;
    sc = '0;
    sd = '0;
    na = '0;
    nb = '0;
    nc = '0;
    nd = '0;
    w_nxt = w_r;
    if (ucw.load) begin
      w_nxt = init;
    end else if (ucw.qr) begin
      for (int l = 0; l < 4; l++) begin
        sa = w_r[l];
        if (ucw.diag) begin
          sb = w_r[4 + ((l + 1) & 3)];
          sc = w_r[8 + ((l + 2) & 3)];
          sd = w_r[12 + ((l + 3) & 3)];
        end else begin
          sb = w_r[4 + l];
          sc = w_r[8 + l];
          sd = w_r[12 + l];
        end
        if (ucw.cd) begin
          na = sa;
          nd = sd;
          nc = sc + sd;
          nb = rotl_sel(sb ^ nc, ucw.rot);
        end else begin
          nb = sb;
          nc = sc;
          na = sa + sb;
          nd = rotl_sel(sd ^ na, ucw.rot);
        end
        w_nxt[l] = na;
        if (ucw.diag) begin
          w_nxt[4 + ((l + 1) & 3)]  = nb;
          w_nxt[8 + ((l + 2) & 3)]  = nc;
          w_nxt[12 + ((l + 3) & 3)] = nd;
        end else begin
          w_nxt[4 + l]  = nb;
          w_nxt[8 + l]  = nc;
          w_nxt[12 + l] = nd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r      <= '0;
      key1_r      <= '0;
      key2_r      <= '0;
      key3_r      <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_blk_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KEY_PART0:  key0_r      <= cfg_wdata;
        CFG_KEY_PART1:  key1_r      <= cfg_wdata;
        CFG_KEY_PART2:  key2_r      <= cfg_wdata;
        CFG_KEY_PART3:  key3_r      <= cfg_wdata;
        CFG_NONCE_LOW:  nonce_lo_r  <= cfg_wdata;
        CFG_NONCE_HIGH: nonce_hi_r  <= cfg_wdata[31:0];
        CFG_START_BLK:  start_blk_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= UpcLoad;
      rnd_r       <= '0;
      in_msg_r    <= 1'b0;
      pos_r       <= '0;
      fresh_r     <= 1'b0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        upc_r  <= UpcLoad;
        if (!in_msg_r) begin
          blk_r    <= start_blk_r;
          in_msg_r <= 1'b1;
        end
      end
      if (busy_r) begin
        if (ucw.loop && (rnd_r != LastDoubleRound)) begin
          upc_r <= ucw.jmp;
          rnd_r <= rnd_r + RndW'(1);
        end else begin
          upc_r <= upc_r + UpcW'(1);
        end
        if (ucw.load) begin
          rnd_r <= '0;
        end
        if (ucw.fin) begin
          busy_r  <= 1'b0;
          fresh_r <= 1'b1;
          blk_r   <= blk_r + 32'd1;
        end
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
        fresh_r     <= 1'b0;
        if (in_data.is_last) begin
          in_msg_r <= 1'b0;
          pos_r    <= '0;
        end else begin
          pos_r    <= pos_r + 6'd1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (busy_r && ucw.fin) begin
      for (int i = 0; i < 16; i++) begin
        ks_r[i] <= w_r[i] + init[i];
      end
    end
    if (in_fire) begin
      out_data_r.out_byte <= in_data.in_byte ^ ks_byte;
      out_data_r.out_last <= in_data.is_last;
    end
  end

  a_fin_arms: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && ucw.fin |=> !busy_r && fresh_r)
    else $error("block build did not finish cleanly");

  a_fire_has_ks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> in_msg_r && ((pos_r != 6'd0) || fresh_r))
    else $error("request taken without a current keystream block");

  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= LastDoubleRound)
    else $error("double-round count out of range");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && (upc_r == UpcLoad))
    else $error("sequencer did not enter the load step");

endmodule

FILE: tb/chacha20_stream_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_tb
// Self-checking bench for the ChaCha20 byte cipher. A scoreboard builds its
// own keystream blocks from the programmed key, nonce and start counter and
// predicts every output byte. Requests are short directed messages, then
// random messages of mixed length under several key settings, including
// counter wrap, register rewrites inside open messages and random stalls.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_tb;
  import cc20_pkg::*;

  localparam int unsigned MaxCycles   = 600000;
  localparam int unsigned TotalItems  = 1300;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned TailCycles  = 100;
  localparam int unsigned IdlePct     = 31;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned NumRegs     = 7;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  class cipher_scoreboard;
    logic [63:0] key_reg[4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] first_block;
    logic [31:0] ks_words[16];
    logic [31:0] st[16];
    logic [5:0]  pos;
    logic [31:0] blk_ctr;
    bit          open_msg;
    out_item_t   expected_q[$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      nonce_lo    = '0;
      nonce_hi    = '0;
      first_block = '0;
      pos         = '0;
      blk_ctr     = '0;
      open_msg    = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [63:0] v);
      case (idx)
        CFG_KEY_PART0:  key_reg[0] = v;
        CFG_KEY_PART1:  key_reg[1] = v;
        CFG_KEY_PART2:  key_reg[2] = v;
        CFG_KEY_PART3:  key_reg[3] = v;
        CFG_NONCE_LOW:  nonce_lo = v;
        CFG_NONCE_HIGH: nonce_hi = v[31:0];
        CFG_START_BLK:  first_block = v[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void qround(int a, int b, int c, int d);
      st[a] += st[b]; st[d] = rotl(st[d] ^ st[a], 16);
      st[c] += st[d]; st[b] = rotl(st[b] ^ st[c], 12);
      st[a] += st[b]; st[d] = rotl(st[d] ^ st[a], 8);
      st[c] += st[d]; st[b] = rotl(st[b] ^ st[c], 7);
    endfunction

    function void make_block();
      logic [31:0] init_st[16];
      init_st[0] = Sigma0;
      init_st[1] = Sigma1;
      init_st[2] = Sigma2;
      init_st[3] = Sigma3;
      for (int i = 0; i < 4; i++) begin
        init_st[4 + 2 * i] = key_reg[i][31:0];
        init_st[5 + 2 * i] = key_reg[i][63:32];
      end
      init_st[12] = blk_ctr;
      init_st[13] = nonce_lo[31:0];
      init_st[14] = nonce_lo[63:32];
      init_st[15] = nonce_hi;
      for (int i = 0; i < 16; i++) st[i] = init_st[i];
      for (int r = 0; r < 10; r++) begin
        qround(0, 4, 8, 12);
        qround(1, 5, 9, 13);
        qround(2, 6, 10, 14);
        qround(3, 7, 11, 15);
        qround(0, 5, 10, 15);
        qround(1, 6, 11, 12);
        qround(2, 7, 8, 13);
        qround(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = st[i] + init_st[i];
      blk_ctr = blk_ctr + 32'd1;
    endfunction

    function void note_request(in_item_t req);
      logic [31:0] word;
      out_item_t   exp_item;
      if (!open_msg) begin
        blk_ctr  = first_block;
        pos      = '0;
        open_msg = 1'b1;
        make_block();
      end else if (pos == 6'd0) begin
        make_block();
      end
      word = ks_words[pos[5:2]];
      exp_item.out_byte = req.in_byte ^ word[8 * pos[1:0] +: 8];
      exp_item.out_last = req.is_last;
      expected_q.push_back(exp_item);
      pos = pos + 6'd1;
      if (req.is_last) begin
        open_msg = 1'b0;
        pos      = '0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected byte %02h last %0b", $time, got.out_byte, got.out_last);
        return;
      end
      exp_item = expected_q.pop_front();
      if (got !== exp_item) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   $time, exp_item.out_byte, exp_item.out_last, got.out_byte, got.out_last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  cipher_scoreboard    sb = new();
  bit                  calm = 1'b0;
  int unsigned         sent = 0;
  int unsigned         cycles = 0;

  chacha20_stream_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MaxCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    in_item_t req;
    req.in_byte = data;
    req.is_last = last;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(input logic [63:0] vals[NumRegs]);
    for (int i = 0; i < NumRegs; i++) write_reg(cfg_reg_t'(i), vals[i]);
    if ($urandom_range(1) == 1) write_reg(CfgIdxSpare, {$urandom, $urandom});
    end_cfg();
  endtask

  task automatic send_message(input int unsigned len, input bit close);
    int unsigned split;
    split = len;
    if (len >= 20 && $urandom_range(3) == 0) split = $urandom_range(len - 2, 1);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == split) begin
        // rewrite one register while the message stays open
        drain();
        write_reg(cfg_reg_t'($urandom_range(NumRegs - 1)), {$urandom, $urandom});
        end_cfg();
      end
      send_byte($urandom_range(255), close && (i == len - 1));
    end
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(8, 1);
    if (r < 80) return $urandom_range(70, 9);
    return $urandom_range(200, 60);
  endfunction

  initial begin
    logic [63:0] vals[NumRegs];
    int unsigned budget;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumRegs; i++) vals[i] = '0;
    program_all(vals);
    write_reg(CfgIdxSpare, '1);
    end_cfg();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);

    drain();
    for (int i = 0; i < NumRegs; i++) vals[i] = '1;
    program_all(vals);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);

    drain();
    for (int i = 0; i < NumRegs; i++) vals[i] = {$urandom, $urandom};
    program_all(vals);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    // open message: key change applies at the next block
    drain();
    write_reg(CFG_KEY_PART2, {$urandom, $urandom});
    write_reg(CFG_START_BLK, {$urandom, $urandom});
    end_cfg();
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(8'h9A, 1'b1);

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: for (int i = 0; i < NumRegs; i++) vals[i] = '0;
        1: for (int i = 0; i < NumRegs; i++) vals[i] = '1;
        default: for (int i = 0; i < NumRegs; i++) vals[i] = {$urandom, $urandom};
      endcase
      if (ph == 3) vals[CFG_START_BLK] = 64'hFFFF_FFFF - $urandom_range(2);
      program_all(vals);
      calm = (ph == 2);
      budget = sent;
      if (sent < TotalItems) budget = sent + (TotalItems - sent) / (NumPhases - ph);
      while (sent < budget) begin
        if (ph == 1 || ph == 3) send_message($urandom_range(200, 65), 1'b1);
        else send_message(pick_len(), 1'b1);
      end
      // leave a message open across some setting changes
      if (ph + 1 < NumPhases && $urandom_range(1) == 1)
        send_message($urandom_range(40, 1), 1'b0);
    end
    calm = 1'b0;

    drain();
    repeat (TailCycles) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
